// ===== src/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and codes for the min-tracking stack: item structs,
// operation codes, status codes and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int MTS_DEPTH = 256;

    typedef logic [1:0] t_func;
    typedef logic [1:0] t_status;

    localparam t_func FUNC_PUSH  = 2'd0;
    localparam t_func FUNC_POP   = 2'd1;
    localparam t_func FUNC_QUERY = 2'd2;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_OVERFLOW  = 2'd1;
    localparam t_status ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        t_func              func;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic signed [31:0] min_value;
        logic               is_empty;
        t_status            status;
    } t_out_item;

    // one stack entry: stored value and running minimum at that depth
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] min;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic exec;      // apply the accepted item from the top registers
        logic rd_en;     // read the entry below the top (pop with 2+ entries)
        logic load_pop;  // move the read entry into the top registers
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // result register can take a new item this cycle
        logic pop_deep;  // incoming item is a pop that exposes a stored entry
    } t_dp_stat;

endpackage

// ===== src/mts_datapath.sv =====
// ----------------------------------------------------------------------------
// mts_datapath
// Top-of-stack registers, entry memory, entry count and result register.
// ----------------------------------------------------------------------------
module mts_datapath #(
    parameter int DEPTH = mts_pkg::MTS_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mts_pkg::t_ctl_cmd i_cmd,
    output mts_pkg::t_dp_stat o_stat,
    input  mts_pkg::t_in_item i_in,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output mts_pkg::t_out_item o_out
);
    import mts_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count, n_count;
    t_entry        r_top, n_top;
    t_entry        r_mem [DEPTH];
    t_entry        r_rd_data;
    t_out_item     r_out, n_out;
    logic          r_out_valid;
    t_status       res_status;
    logic          wr_en;
    logic          out_load;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          is_zero;
    logic          is_one;
    logic          is_full;

    assign is_zero = (r_count == '0);
    assign is_one  = (r_count == CW'(1));
    assign is_full = (r_count == CW'(DEPTH));

    // top sits in registers; memory holds the entries below it
    assign wr_addr = AW'(r_count - CW'(1));
    assign rd_addr = AW'(r_count - CW'(2));

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_stat.pop_deep = (i_in.func == FUNC_POP) && !is_zero && !is_one;

    always_comb begin
        n_count    = r_count;
        n_top      = r_top;
        wr_en      = 1'b0;
        res_status = ST_OK;
        if (i_cmd.exec) begin
            unique case (i_in.func)
                FUNC_PUSH: begin
                    if (is_full) begin
                        res_status = ST_OVERFLOW;
                    end else begin
                        wr_en       = !is_zero;
                        n_top.value = i_in.value;
                        n_top.min   = (is_zero || (i_in.value < r_top.min)) ?
                                      i_in.value : r_top.min;
                        n_count     = r_count + CW'(1);
                    end
                end
                FUNC_POP: begin
                    if (is_zero) begin
                        res_status = ST_UNDERFLOW;
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end
                default: begin
                    // query and unused code: hold everything
                end
            endcase
        end else if (i_cmd.load_pop) begin
            n_top   = r_rd_data;
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        n_out.is_empty  = (n_count == '0);
        n_out.top_value = n_out.is_empty ? 32'sd0 : n_top.value;
        n_out.min_value = n_out.is_empty ? 32'sd0 : n_top.min;
        n_out.status    = res_status;
    end

    assign out_load = i_cmd.exec || i_cmd.load_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_top;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.status == ST_UNDERFLOW) |-> r_out.is_empty)
        else $error("underflow reported on a non-empty stack");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("result lost after load");

    a_load_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.exec && i_cmd.load_pop))
        else $error("execute and pop load in the same cycle");

endmodule

// ===== src/mts_ctrl.sv =====
// ----------------------------------------------------------------------------
// mts_ctrl
// Sequencer: accepts items, splits deep pops into read and load steps.
// ----------------------------------------------------------------------------
module mts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mts_pkg::t_dp_stat i_stat,
    output mts_pkg::t_ctl_cmd o_cmd
);
    import mts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOAD = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_stall = !((r_state == S_IDLE) && i_stat.out_free);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_stat.pop_deep) begin
                        o_cmd.rd_en = 1'b1;
                        n_state     = S_LOAD;
                    end else begin
                        o_cmd.exec = 1'b1;
                    end
                end
            end
            S_LOAD: begin
                // wait for room in the result register
                if (i_stat.out_free) begin
                    o_cmd.load_pop = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |=> (r_state == S_LOAD))
        else $error("pop read not followed by load step");

endmodule

// ===== src/min_tracking_stack.sv =====
// ----------------------------------------------------------------------------
// min_tracking_stack
// LIFO of signed 32-bit values with a running minimum per entry.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one item: func
//   (push, pop, query) and the value to push. Output channel (o_out_valid /
//   i_out_stall / o_out) returns one item per input: top value, minimum,
//   empty flag and status (ok, overflow, underflow).
//   The result is written to the result register as the item is accepted. A pop that
//   leaves at least one entry takes one more cycle, since the new top must
//   be read from the entry memory (registered read port).
//   Throughput: one item per cycle while the output is not stalled, for push,
//   query, failed operations and a pop down to empty; a pop that exposes a
//   stored entry holds off the next item while the new top is read from the
//   entry memory behind the top registers (registered read port).
//   Reset: synchronous, active low; the stack comes up empty and no result
//   is pending. Entry memory is not cleared; only written entries are read.
//   Stall: a result held by i_out_stall stays in the result register and
//   raises o_in_stall until it is taken, so no item is lost or repeated.
// ----------------------------------------------------------------------------
module min_tracking_stack #(
    parameter int DEPTH = mts_pkg::MTS_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mts_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mts_pkg::t_out_item o_out
);
    import mts_pkg::*;

    // command and status between sequencer and datapath
    t_ctl_cmd cmd;
    t_dp_stat stat;

    // sequencer: accept items, split deep pops into read then load
    mts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: top registers, entry memory, count and result register
    mts_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// ===== test/min_stack_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_stack_checker
// Watches both channels of the min-tracking stack, predicts each result item
// from its own copy of the stack and compares every returned item field by
// field.
// ----------------------------------------------------------------------------
module min_stack_checker #(
    parameter int DEPTH = mts_pkg::MTS_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  mts_pkg::t_in_item  i_in,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  mts_pkg::t_out_item i_out,
    output int                 o_fail_count,
    output int                 o_pending
);
    import mts_pkg::*;

    logic signed [31:0] stack_vals [DEPTH];
    logic signed [31:0] stack_mins [DEPTH];
    int                 depth_used;
    t_out_item          predicted_reports [$];
    int                 fail_count;
    int                 pending;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    // Apply one operation to the shadow stack and build the item it causes.
    function automatic t_out_item apply_stack_op(t_in_item op);
        t_out_item          rep;
        logic signed [31:0] run_min;
        rep.status = ST_OK;
        case (op.func)
            FUNC_PUSH: begin
                if (depth_used >= DEPTH) begin
                    rep.status = ST_OVERFLOW;
                end else begin
                    run_min = op.value;
                    if (depth_used != 0 && stack_mins[depth_used - 1] < op.value)
                        run_min = stack_mins[depth_used - 1];
                    stack_vals[depth_used] = op.value;
                    stack_mins[depth_used] = run_min;
                    depth_used++;
                end
            end
            FUNC_POP: begin
                if (depth_used == 0)
                    rep.status = ST_UNDERFLOW;
                else
                    depth_used--;
            end
            default: ;
        endcase
        if (depth_used == 0) begin
            rep.top_value = '0;
            rep.min_value = '0;
            rep.is_empty  = 1'b1;
        end else begin
            rep.top_value = stack_vals[depth_used - 1];
            rep.min_value = stack_mins[depth_used - 1];
            rep.is_empty  = 1'b0;
        end
        return rep;
    endfunction

    task automatic note_failure(string what, t_out_item want, t_out_item got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t mismatch (%s): want top=%0d min=%0d empty=%0b st=%0d,",
                     $time, what, want.top_value, want.min_value, want.is_empty,
                     want.status);
            $display("    got top=%0d min=%0d empty=%0b st=%0d",
                     got.top_value, got.min_value, got.is_empty, got.status);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            depth_used = 0;
            fail_count = 0;
            pending    = 0;
            predicted_reports.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (predicted_reports.size() == 0) begin
                    note_failure("unexpected item", '0, i_out);
                end else begin
                    want = predicted_reports.pop_front();
                    if (want.top_value !== i_out.top_value)
                        note_failure("top_value", want, i_out);
                    else if (want.min_value !== i_out.min_value)
                        note_failure("min_value", want, i_out);
                    else if (want.is_empty !== i_out.is_empty)
                        note_failure("is_empty", want, i_out);
                    else if (want.status !== i_out.status)
                        note_failure("status", want, i_out);
                end
            end
            if (i_in_valid && !i_in_stall)
                predicted_reports.push_back(apply_stack_op(i_in));
            pending = predicted_reports.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the min-tracking stack with directed corner items, then a random run
// that climbs to a full stack and drains back to empty, under bursty input
// and patterned output stall; a side checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
    import mts_pkg::*;

    localparam int    DEPTH      = MTS_DEPTH;
    localparam int    LIMIT      = 200000;  // cycles before the run is declared hung
    localparam int    HOLD_AT    = 100;     // accepted items before the long hold
    localparam int    HOLD_LEN   = 150;     // cycles the receiver holds off
    localparam t_func FUNC_SPARE = 2'd3;    // unused selector, behaves as a query

    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       in_stall;
    t_in_item   in_item;
    logic       out_valid;
    logic       out_stall;
    t_out_item  out_item;
    int         fail_count;
    int         pending;

    // sender bookkeeping: burst length left and a fill level, used only
    // to steer the random part toward full and back to empty
    int         burst_left;
    int         level;

    // receiver bookkeeping
    int         accepted;
    int         hold_left;
    logic       hold_done;
    int         stall_mode;
    int         mode_left;
    int         cycles;

    min_tracking_stack #(.DEPTH(DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    min_stack_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Hang guard: end the run as a failure once the cycle count passes LIMIT.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: stall on a pattern that switches between free-running, light
    // and heavy stall, and once hold off for a long stretch so that the block
    // fills up and pushes back on its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            accepted   <= 0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
            stall_mode <= 0;
            mode_left  <= 0;
        end else begin
            if (in_valid && !in_stall)
                accepted <= accepted + 1;
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (!hold_done && accepted >= HOLD_AT) begin
                out_stall <= 1'b1;
                hold_left <= HOLD_LEN;
                hold_done <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode <= $urandom_range(0, 2);
                    mode_left  <= $urandom_range(16, 64);
                end else begin
                    mode_left <= mode_left - 1;
                end
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 99) < 30);
                    default: out_stall <= ($urandom_range(0, 99) < 70);
                endcase
            end
        end
    end

    // Random push value: extremes, a narrow band around zero so that equal
    // minima come up often, and full-range values.
    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 15);
        case (sel)
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return 32'sd0;
            3:       return -32'sd1;
            4, 5, 6: return 32'($urandom_range(0, 16)) - 32'sd8;
            default: return 32'($urandom);
        endcase
    endfunction

    // Offer one item and hold it until accepted. A new burst starts with a
    // random gap, skipped while the receiver holds off so input keeps coming.
    task automatic send_op(t_func func, logic signed [31:0] value);
        t_in_item op;
        int       gap;
        if (burst_left == 0) begin
            gap = (hold_left != 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        op.func  = func;
        op.value = value;
        in_item  <= op;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        burst_left--;
        if (func == FUNC_PUSH && level < DEPTH)
            level++;
        else if (func == FUNC_POP && level > 0)
            level--;
    endtask

    // Random item with the given push and pop weights in percent; the rest
    // splits between query and the unused selector.
    task automatic send_random(int push_pct, int pop_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            send_op(FUNC_PUSH, pick_value());
        else if (roll < push_pct + pop_pct)
            send_op(FUNC_POP, pick_value());
        else if ($urandom_range(0, 3) == 0)
            send_op(FUNC_SPARE, pick_value());
        else
            send_op(FUNC_QUERY, pick_value());
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        in_valid   <= 1'b0;
        in_item    <= '0;
        burst_left = 0;
        level      = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-stack cases first.
        send_op(FUNC_QUERY, 32'sd0);
        send_op(FUNC_POP, 32'sd7);           // underflow, stack stays empty
        send_op(FUNC_SPARE, VAL_MAX);        // unused selector acts as query
        // Extremes and minimum tracking.
        send_op(FUNC_PUSH, VAL_MAX);
        send_op(FUNC_PUSH, VAL_MIN);         // new minimum
        send_op(FUNC_PUSH, 32'sd5);          // minimum holds
        send_op(FUNC_QUERY, 32'sh5555_5555);
        send_op(FUNC_POP, 32'sd0);
        send_op(FUNC_POP, 32'sd0);           // back to a single max entry
        send_op(FUNC_PUSH, VAL_MAX);         // equal to the minimum
        send_op(FUNC_PUSH, -32'sd1);
        send_op(FUNC_PUSH, -32'sd1);         // equal to the minimum again
        send_op(FUNC_PUSH, 32'sh5555_5555);
        send_op(FUNC_PUSH, 32'shAAAA_AAAA);  // negative, becomes the minimum
        send_op(FUNC_SPARE, 32'shAAAA_AAAA);
        repeat (5)
            send_op(FUNC_POP, 32'sd0);       // last one leaves a single max entry
        send_op(FUNC_POP, VAL_MIN);          // last entry goes, stack drops to empty
        send_op(FUNC_PUSH, 32'sd0);
        send_op(FUNC_POP, 32'sd0);

        // Random: a balanced warm-up, a climb to full with overflow attempts,
        // a drain to empty with underflow attempts, then a mixed tail.
        repeat (12)
            send_random(40, 35);
        while (level < DEPTH)
            send_random(96, 2);
        repeat (6)
            send_random(80, 0);
        while (level > 0)
            send_random(2, 96);
        repeat (4)
            send_random(0, 80);
        repeat (12)
            send_random(45, 40);
        in_valid <= 1'b0;

        // Drain: wait for every predicted result, then a few quiet cycles.
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
